// ===== rtl/core/ihex_pkg.sv =====
// ----------------------------------------------------------------------------
// ihex_pkg: shared types and constants for the Intel HEX record loader
// Parser phase codes, result kinds, character and record-type constants.
// ----------------------------------------------------------------------------
package ihex_pkg;

    // Parser phase, one-hot
    typedef enum logic [7:0] {
        PH_COLON   = 8'b0000_0001,
        PH_COUNT   = 8'b0000_0010,
        PH_ADDR_HI = 8'b0000_0100,
        PH_ADDR_LO = 8'b0000_1000,
        PH_TYPE    = 8'b0001_0000,
        PH_DATA    = 8'b0010_0000,
        PH_SKIP    = 8'b0100_0000,
        PH_HALT    = 8'b1000_0000
    } phase_t;

    // Result kinds
    localparam logic [1:0] KIND_WRITE = 2'd0;
    localparam logic [1:0] KIND_END   = 2'd1;
    localparam logic [1:0] KIND_ERROR = 2'd2;

    // Characters
    localparam logic [7:0] CHAR_COLON = 8'h3A;
    localparam logic [7:0] CHAR_LF    = 8'h0A;
    localparam logic [7:0] CHAR_0     = 8'h30;
    localparam logic [7:0] CHAR_9     = 8'h39;
    localparam logic [7:0] CHAR_A     = 8'h41;
    localparam logic [7:0] CHAR_F     = 8'h46;

    // Record types
    localparam logic [7:0] REC_DATA = 8'h00;
    localparam logic [7:0] REC_EOF  = 8'h01;

    // Parser state
    typedef struct packed {
        phase_t      phase;
        logic [3:0]  high_nibble;
        logic        second_digit;
        logic [7:0]  bytes_left;
        logic [15:0] cur_address;
    } parse_state_t;

    // One result of a character
    typedef struct packed {
        logic        valid;
        logic [1:0]  kind;
        logic [15:0] address;
        logic [7:0]  data;
    } parse_result_t;

endpackage

// ===== rtl/core/ihex_decoder.sv =====
// ----------------------------------------------------------------------------
// ihex_decoder: per-character next-state and result logic
// Pure combinational step of the record parser for one input character.
// ----------------------------------------------------------------------------
module ihex_decoder
    import ihex_pkg::*;
(
    input  parse_state_t  cur,
    input  logic [7:0]    char_in,
    output parse_state_t  nxt,
    output parse_result_t res
);

    logic       is_hex;
    logic [3:0] nibble;
    logic [7:0] byte_val;

    always_comb
    begin
        is_hex = 1'b0;
        nibble = 4'd0;
        if (char_in >= CHAR_0 && char_in <= CHAR_9)
        begin
            is_hex = 1'b1;
            nibble = char_in[3:0];
        end
        else if (char_in >= CHAR_A && char_in <= CHAR_F)
        begin
            is_hex = 1'b1;
            nibble = char_in[3:0] + 4'd9;   // 'A' low nibble is 1
        end
    end

    assign byte_val = {cur.high_nibble, nibble};

    always_comb
    begin
        nxt = cur;
        res = '0;
        unique case (cur.phase)
            PH_HALT:
            begin
            end
            PH_COLON:
            begin
                if (char_in != CHAR_COLON)
                begin
                    nxt.phase = PH_HALT;
                    res.valid = 1'b1;
                    res.kind  = KIND_ERROR;
                end
                else
                begin
                    nxt.phase        = PH_COUNT;
                    nxt.second_digit = 1'b0;
                end
            end
            PH_SKIP:
            begin
                if (char_in == CHAR_LF)
                    nxt.phase = PH_COLON;
            end
            default:
            begin
                if (!is_hex)
                begin
                    nxt.phase = PH_HALT;
                    res.valid = 1'b1;
                    res.kind  = KIND_ERROR;
                end
                else if (!cur.second_digit)
                begin
                    nxt.high_nibble  = nibble;
                    nxt.second_digit = 1'b1;
                end
                else
                begin
                    nxt.second_digit = 1'b0;
                    unique case (cur.phase)
                        PH_COUNT:
                        begin
                            nxt.bytes_left = byte_val;
                            nxt.phase      = PH_ADDR_HI;
                        end
                        PH_ADDR_HI:
                        begin
                            nxt.cur_address = {byte_val, 8'h00};
                            nxt.phase       = PH_ADDR_LO;
                        end
                        PH_ADDR_LO:
                        begin
                            nxt.cur_address = {cur.cur_address[15:8], byte_val};
                            nxt.phase       = PH_TYPE;
                        end
                        PH_TYPE:
                        begin
                            if (byte_val == REC_EOF)
                            begin
                                nxt.phase = PH_HALT;
                                res.valid = 1'b1;
                                res.kind  = KIND_END;
                            end
                            else if (byte_val == REC_DATA && cur.bytes_left != 8'd0)
                                nxt.phase = PH_DATA;
                            else
                                nxt.phase = PH_SKIP;
                        end
                        PH_DATA:
                        begin
                            nxt.cur_address = cur.cur_address + 16'd1;
                            nxt.bytes_left  = cur.bytes_left - 8'd1;
                            if (cur.bytes_left == 8'd1)
                                nxt.phase = PH_SKIP;
                            res.valid   = 1'b1;
                            res.kind    = KIND_WRITE;
                            res.address = cur.cur_address;
                            res.data    = byte_val;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
        endcase
    end

endmodule

// ===== rtl/core/intel_hex_record_loader.sv =====
// ----------------------------------------------------------------------------
// intel_hex_record_loader: Intel HEX text to memory-write stream
// Parses records one character per transfer and emits writes, end, or error.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready/char_in) carries one ASCII character of
//   the file per transfer. Output channel (out_valid/out_ready) carries at
//   most one result per character: kind 0 is a memory write (write_address,
//   write_data), kind 1 the end-of-file record, kind 2 a format error.
//   Address and data read zero for kinds other than a write.
//   Throughput: one character per cycle while no result waits on a low
//   out_ready. The parser step is a single pass of next-state logic from
//   the state register; it is the only loop. The output register takes a
//   result in the cycle after the character transfer that caused it.
//   Stall: while a result waits and out_ready is low, in_ready drops; in a
//   cycle where the result is taken a new character is accepted too.
//   Reset: rst_n clears the parser to wait for a colon and empties the
//   output register. After an end record or an error the parser halts and
//   swallows all further characters until reset.
// ----------------------------------------------------------------------------
module intel_hex_record_loader
    import ihex_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  char_in,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  kind,
    output logic [15:0] write_address,
    output logic [7:0]  write_data
);

    parse_state_t  state_reg;
    parse_state_t  state_next;
    parse_result_t step_res;

    logic          out_valid_reg;
    logic [1:0]    kind_reg;
    logic [15:0]   address_reg;
    logic [7:0]    data_reg;
    logic          in_xfer;

    ihex_decoder u_decoder (
        .cur     (state_reg),
        .char_in (char_in),
        .nxt     (state_next),
        .res     (step_res)
    );

    // Output slot is free, or frees up this cycle
    assign in_ready = !out_valid_reg || out_ready;
    assign in_xfer  = in_valid && in_ready;

    // Parser state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.phase        <= PH_COLON;
            state_reg.high_nibble  <= 4'd0;
            state_reg.second_digit <= 1'b0;
            state_reg.bytes_left   <= 8'd0;
            state_reg.cur_address  <= 16'd0;
        end
        else if (in_xfer)
        begin
            state_reg <= state_next;
        end
    end

    // Output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (in_xfer && step_res.valid)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    // Output payload, no reset
    always_ff @(posedge clk)
    begin
        if (in_xfer && step_res.valid)
        begin
            kind_reg    <= step_res.kind;
            address_reg <= step_res.address;
            data_reg    <= step_res.data;
        end
    end

    assign out_valid     = out_valid_reg;
    assign kind          = kind_reg;
    assign write_address = address_reg;
    assign write_data    = data_reg;

endmodule
